>>> src/gprc_pkg.sv
// Shared constants, item type and rounding function of the Givens rotation cascade.
package gprc_pkg;

  localparam int MaxLayers = 8;
  localparam int MaxLength = 256;
  localparam int DataW     = 16;
  localparam int CoefW     = 16;
  localparam int CoefFrac  = 14;

  localparam int Pairs    = (MaxLength + 1) / 2;
  localparam int PairAw   = $clog2(Pairs);
  localparam int PairW    = 7;
  localparam int LayerW   = 3;
  localparam int CountW   = 4;
  localparam int LengthW  = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int ProdW    = DataW + CoefW;
  localparam int SumW     = ProdW + 1;
  localparam int QW       = SumW + 1 - CoefFrac;

  localparam logic [CfgIdxW-1:0] CfgLayerCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVectorLength = 2'd1;

  typedef struct packed {
    logic                    valid;
    logic                    rot;
    logic                    tail;
    logic                    pok;
    logic [LayerW-1:0]       layer;
    logic [PairW-1:0]        pair;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [CoefW-1:0] cw;
    logic signed [CoefW-1:0] sw;
  } item_t;

  function automatic logic signed [DataW-1:0] round_sat(input logic signed [SumW-1:0] sum);
    logic signed [SumW:0]   t;
    logic signed [QW-1:0]   q;
    logic signed [DataW-1:0] r;
    t = $signed({sum[SumW-1], sum}) + $signed((SumW + 1)'(1 << (CoefFrac - 1)));
    q = QW'(t >>> CoefFrac);
    if ((&q[QW-1:DataW-1]) || (~|q[QW-1:DataW-1])) begin
      r = q[DataW-1:0];
    end else if (q[QW-1]) begin
      r = {1'b1, {(DataW - 1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW - 1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/gprc_if.sv
// Stream and configuration channel interfaces of the Givens rotation cascade.
interface gprc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [gprc_pkg::LayerW-1:0]       layer_index;
  logic [gprc_pkg::PairW-1:0]        pair_index;
  logic signed [gprc_pkg::DataW-1:0] x_first;
  logic signed [gprc_pkg::DataW-1:0] x_second;
  logic signed [gprc_pkg::CoefW-1:0] cos_value;
  logic signed [gprc_pkg::CoefW-1:0] sin_value;

  modport source (output valid, kind, layer_index, pair_index, x_first, x_second,
                  cos_value, sin_value, input ready);
  modport sink   (input valid, kind, layer_index, pair_index, x_first, x_second,
                  cos_value, sin_value, output ready);
endinterface

interface gprc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gprc_pkg::DataW-1:0] y_first;
  logic signed [gprc_pkg::DataW-1:0] y_second;
  logic                              second_valid;

  modport source (output valid, y_first, y_second, second_valid, input ready);
  modport sink   (input valid, y_first, y_second, second_valid, output ready);
endinterface

interface gprc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gprc_pkg::CfgIdxW-1:0]   index;
  logic [gprc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/givens_pair_rotation_cascade_unit.sv
// Top level of the Givens pair rotation cascade.
// Takes one item per cycle and returns each rotate result through a pipeline: the entry
// register takes the item at the accepting edge, then a product stage and a round/saturate
// stage per layer and an output register follow.
// Every layer owns a 128 x 32 coefficient memory;
// a load item writes it when it passes that layer, so loads and rotates act in arrival order
// and a load causes no result. The input stalls only when the output register holds an
// untaken result and the last layer stage holds another one. Configuration writes take
// effect at once and belong to idle periods.
module givens_pair_rotation_cascade_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  gprc_in_if.sink    in_i,
  gprc_out_if.source out_o,
  gprc_cfg_if.sink   cfg_i
);
  import gprc_pkg::*;

  logic [CountW-1:0]  layer_count_q, layer_count_d;
  logic [LengthW-1:0] vector_length_q, vector_length_d;
  logic [CountW-1:0]  layers_eff;
  logic [LengthW-1:0] length_eff;
  logic               adv, take;
  item_t              feed0, e_q, last;
  item_t              prod_w [MaxLayers];
  item_t              res_w  [MaxLayers];
  logic               out_v_q;
  logic signed [DataW-1:0] y_first_q, y_second_q;
  logic               second_valid_q;

  always_comb begin
    layer_count_d   = layer_count_q;
    vector_length_d = vector_length_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLayerCount:   layer_count_d   = cfg_i.data[CountW-1:0];
        CfgVectorLength: vector_length_d = cfg_i.data[LengthW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q   <= CountW'(1);
      vector_length_q <= LengthW'(256);
    end else begin
      layer_count_q   <= layer_count_d;
      vector_length_q <= vector_length_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  assign layers_eff = (layer_count_q > CountW'(MaxLayers)) ? CountW'(MaxLayers) : layer_count_q;
  assign length_eff = (vector_length_q > LengthW'(MaxLength)) ? LengthW'(MaxLength)
                                                                : vector_length_q;

  always_comb begin
    feed0.valid = in_i.valid;
    feed0.rot   = in_i.kind;
    feed0.tail  = in_i.kind && (LengthW'({in_i.pair_index, 1'b1}) == length_eff);
    feed0.pok   = ({1'b0, in_i.pair_index} < (PairW + 1)'(Pairs));
    feed0.layer = in_i.layer_index;
    feed0.pair  = in_i.pair_index;
    feed0.a     = in_i.x_first;
    feed0.b     = feed0.tail ? '0 : in_i.x_second;
    feed0.cw    = in_i.cos_value;
    feed0.sw    = in_i.sin_value;
  end

  assign last = res_w[MaxLayers-1];
  assign take = out_o.ready || !out_v_q;
  assign adv  = take || !(last.valid && last.rot);
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
    end else if (adv) begin
      e_q <= feed0;
    end
  end

  for (genvar k = 0; k < MaxLayers; k++) begin : g_layer
    item_t feed_k, in_k;
    if (k == 0) begin : g_first
      assign feed_k = feed0;
      assign in_k   = e_q;
    end else begin : g_next
      assign feed_k = prod_w[k-1];
      assign in_k   = res_w[k-1];
    end
    gprc_layer u_layer (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .layer_id_i (LayerW'(k)),
      .layers_i   (layers_eff),
      .feed_i     (feed_k),
      .in_i       (in_k),
      .prod_o     (prod_w[k]),
      .res_o      (res_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take) begin
      out_v_q <= last.valid && last.rot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      y_first_q      <= last.a;
      y_second_q     <= last.tail ? '0 : last.b;
      second_valid_q <= !last.tail;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.y_first      = y_first_q;
  assign out_o.y_second     = y_second_q;
  assign out_o.second_valid = second_valid_q;

endmodule

>>> src/gprc_ram.sv
// Generic single-port RAM with registered read.
module gprc_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/gprc_layer.sv
// One rotation layer: coefficient memory, product stage and round/saturate stage.
module gprc_layer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [gprc_pkg::LayerW-1:0]   layer_id_i,
  input  logic [gprc_pkg::CountW-1:0]   layers_i,
  input  gprc_pkg::item_t               feed_i,
  input  gprc_pkg::item_t               in_i,
  output gprc_pkg::item_t               prod_o,
  output gprc_pkg::item_t               res_o
);
  import gprc_pkg::*;

  logic [2*CoefW-1:0]      coef_rd;
  logic                    we;
  logic signed [CoefW-1:0] c, s;
  logic                    act_d, act_q;
  logic signed [ProdW-1:0] ca_d, sb_d, sa_d, cb_d;
  logic signed [ProdW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [SumW-1:0]  diff, sum;
  item_t                   prod_q, res_d, res_q;

  // write coefficients when the load item passes this layer's read point
  assign we = adv_i && feed_i.valid && !feed_i.rot && feed_i.pok &&
              (feed_i.layer == layer_id_i);

  gprc_ram #(
    .Width (2 * CoefW),
    .Depth (Pairs)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (adv_i),
    .addr_i  (PairAw'(feed_i.pair)),
    .wdata_i ({feed_i.cw, feed_i.sw}),
    .rdata_o (coef_rd)
  );

  always_comb begin
    c     = in_i.pok ? $signed(coef_rd[2*CoefW-1:CoefW]) : '0;
    s     = in_i.pok ? $signed(coef_rd[CoefW-1:0]) : '0;
    act_d = in_i.valid && in_i.rot && (CountW'(layer_id_i) < layers_i);
    ca_d  = c * in_i.a;
    sb_d  = s * in_i.b;
    sa_d  = s * in_i.a;
    cb_d  = c * in_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      act_q  <= 1'b0;
    end else if (adv_i) begin
      prod_q <= in_i;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ca_q <= ca_d;
      sb_q <= sb_d;
      sa_q <= sa_d;
      cb_q <= cb_d;
    end
  end

  always_comb begin
    diff  = SumW'(ca_q) - SumW'(sb_q);
    sum   = SumW'(sa_q) + SumW'(cb_q);
    res_d = prod_q;
    if (act_q) begin
      res_d.a = round_sat(diff);
      res_d.b = prod_q.tail ? '0 : round_sat(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign prod_o = prod_q;
  assign res_o  = res_q;

endmodule

>>> src/gprc_checker.sv
// Port-level assertions of the Givens pair rotation cascade and their bind.
module gprc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [gprc_pkg::DataW-1:0] y_first_i,
  input logic signed [gprc_pkg::DataW-1:0] y_second_i,
  input logic                          second_valid_i,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(y_first_i) && $stable(y_second_i) &&
                                   $stable(second_valid_i))
    else $error("stalled result changed");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !second_valid_i |-> y_second_i == '0)
    else $error("tail result carries nonzero second element");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write refused");

endmodule

bind givens_pair_rotation_cascade_unit gprc_checker u_gprc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .y_first_i      (out_o.y_first),
  .y_second_i     (out_o.y_second),
  .second_valid_i (out_o.second_valid),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready)
);
